@@ src/bsm_pkg.sv @@
// Shared types, codes and constants of the bank switch mapper.
`default_nettype none
package bsm_pkg;

    typedef enum logic [2:0] {
        OP_REG_WRITE = 3'd0,
        OP_PRG_READ  = 3'd1,
        OP_PPU_ADDR  = 3'd2,
        OP_RAM_READ  = 3'd3,
        OP_RAM_WRITE = 3'd4
    } op_t;

    // CPU register space regions, decoded from address bits 14:13.
    localparam logic [1:0] REGION_BANK   = 2'd0;
    localparam logic [1:0] REGION_MIRROR = 2'd1;
    localparam logic [1:0] REGION_LATCH  = 2'd2;
    localparam logic [1:0] REGION_ENABLE = 2'd3;

    localparam logic [1:0] CFG_PRG_BANK_BITS = 2'd0;
    localparam logic [1:0] CFG_CHR_BANK_BITS = 2'd1;
    localparam logic [1:0] CFG_CHR_IS_RAM    = 2'd2;
    localparam logic [1:0] CFG_QUAD_MIRROR   = 2'd3;

    localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIRROR_FOUR       = 2'd2;

    localparam logic [2:0] PRG_BITS_MAX = 3'd6;
    localparam logic [3:0] CHR_BITS_MAX = 4'd8;
    localparam logic [3:0] A12_LOW_NEEDED = 4'd3;

    localparam logic [7:0][7:0] BANK_RESET =
        {8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] address;
        logic [7:0]  value;
    } request_t;

    typedef struct packed {
        logic [18:0] mapped_offset;
        logic        ram_access_ok;
        logic        irq_pulse;
        logic [1:0]  mirroring;
    } result_t;

    typedef struct packed {
        logic [2:0] prg_bank_bits;
        logic [3:0] chr_bank_bits;
        logic       chr_is_ram;
        logic       quad_mirror;
    } cfg_t;

    typedef struct packed {
        logic [7:0][7:0] banks;
        logic            prg_swap_mode;
        logic            chr_invert;
    } map_state_t;

endpackage
`default_nettype wire

@@ src/bsm_bank_regs.sv @@
// Bank select, bank registers, mirroring and PRG RAM control registers.
`default_nettype none
module bsm_bank_regs (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 valid,
    input  wire bsm_pkg::request_t    req,
    input  wire logic                 quad_mirror,
    output bsm_pkg::map_state_t       map_state,
    output logic                      ram_ok,
    output logic                      mirror_next
);

    logic [2:0]      select_reg, select_next;
    logic [7:0][7:0] banks_reg, banks_next;
    logic            swap_reg, swap_next;
    logic            invert_reg, invert_next;
    logic            ram_en_reg, ram_en_next;
    logic            ram_wr_reg, ram_wr_next;
    logic            mirror_reg;
    logic            odd;

    assign odd = req.address[0];

    always_comb
    begin
        select_next = select_reg;
        banks_next  = banks_reg;
        swap_next   = swap_reg;
        invert_next = invert_reg;
        ram_en_next = ram_en_reg;
        ram_wr_next = ram_wr_reg;
        mirror_next = mirror_reg;
        if (valid && req.opcode == bsm_pkg::OP_REG_WRITE && req.address[15])
        begin
            case (req.address[14:13])
                bsm_pkg::REGION_BANK:
                begin
                    if (odd)
                    begin
                        // The 2 KB pair registers always hold an even bank.
                        if (select_reg[2:1] == 2'b00)
                            banks_next[select_reg] = {req.value[7:1], 1'b0};
                        else
                            banks_next[select_reg] = req.value;
                    end
                    else
                    begin
                        select_next = req.value[2:0];
                        swap_next   = req.value[6];
                        invert_next = req.value[7];
                    end
                end
                bsm_pkg::REGION_MIRROR:
                begin
                    if (odd)
                    begin
                        ram_en_next = req.value[7];
                        ram_wr_next = req.value[7] & ~req.value[6];
                    end
                    else if (!quad_mirror)
                        mirror_next = req.value[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (req.opcode)
            bsm_pkg::OP_RAM_READ:  ram_ok = ram_en_reg;
            bsm_pkg::OP_RAM_WRITE: ram_ok = ram_en_reg & ram_wr_reg;
            default:               ram_ok = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg <= 3'd0;
            banks_reg  <= bsm_pkg::BANK_RESET;
            swap_reg   <= 1'b0;
            invert_reg <= 1'b0;
            ram_en_reg <= 1'b1;
            ram_wr_reg <= 1'b1;
            mirror_reg <= 1'b0;
        end
        else
        begin
            select_reg <= select_next;
            banks_reg  <= banks_next;
            swap_reg   <= swap_next;
            invert_reg <= invert_next;
            ram_en_reg <= ram_en_next;
            ram_wr_reg <= ram_wr_next;
            mirror_reg <= mirror_next;
        end
    end

    assign map_state.banks         = banks_reg;
    assign map_state.prg_swap_mode = swap_reg;
    assign map_state.chr_invert    = invert_reg;

endmodule
`default_nettype wire

@@ src/bsm_irq.sv @@
// A12 edge filter and scanline interrupt counter with its control registers.
`default_nettype none
module bsm_irq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid,
    input  wire bsm_pkg::request_t req,
    output logic                   irq_pulse
);

    logic [7:0] latch_reg, latch_next;
    logic [7:0] count_reg, count_next;
    logic       pending_reg, pending_next;
    logic       on_reg, on_next;
    logic       last_reg, last_next;
    logic [3:0] low_reg, low_next;

    always_comb
    begin
        latch_next   = latch_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        on_next      = on_reg;
        last_next    = last_reg;
        low_next     = low_reg;
        irq_pulse    = 1'b0;
        if (valid && req.opcode == bsm_pkg::OP_REG_WRITE && req.address[15])
        begin
            case (req.address[14:13])
                bsm_pkg::REGION_LATCH:
                begin
                    if (req.address[0])
                        pending_next = 1'b1;
                    else
                        latch_next = req.value;
                end
                bsm_pkg::REGION_ENABLE: on_next = req.address[0];
                default:
                begin
                end
            endcase
        end
        else if (valid && req.opcode == bsm_pkg::OP_PPU_ADDR)
        begin
            if (!req.address[12])
            begin
                last_next = 1'b0;
                if (low_reg < bsm_pkg::A12_LOW_NEEDED)
                    low_next = low_reg + 4'd1;
            end
            else
            begin
                // Only a rising edge after a long enough low period counts.
                if (!last_reg && low_reg >= bsm_pkg::A12_LOW_NEEDED)
                begin
                    if (count_reg == 8'd0 || pending_reg)
                    begin
                        count_next   = latch_reg;
                        pending_next = 1'b0;
                    end
                    else
                        count_next = count_reg - 8'd1;
                    irq_pulse = (count_next == 8'd0) && on_reg;
                end
                last_next = 1'b1;
                low_next  = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg   <= 8'd0;
            count_reg   <= 8'd0;
            pending_reg <= 1'b0;
            on_reg      <= 1'b0;
            last_reg    <= 1'b0;
            low_reg     <= 4'd0;
        end
        else
        begin
            latch_reg   <= latch_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            on_reg      <= on_next;
            last_reg    <= last_next;
            low_reg     <= low_next;
        end
    end

endmodule
`default_nettype wire

@@ src/bsm_map.sv @@
// Program and character address translation through the bank windows.
`default_nettype none
module bsm_map (
    input  wire bsm_pkg::request_t   req,
    input  wire bsm_pkg::map_state_t map_state,
    input  wire bsm_pkg::cfg_t       cfg,
    output logic [18:0]              mapped_offset
);

    logic [2:0] pbits;
    logic [6:0] pcount;
    logic [5:0] pmask;
    logic [5:0] psecond;
    logic [7:0] praw;
    logic [5:0] pbank;
    logic [3:0] cbits;
    logic [8:0] ccount;
    logic [7:0] cmask;
    logic [2:0] cslot;
    logic [7:0] craw;
    logic [17:0] chr_rom;

    always_comb
    begin
        pbits   = (cfg.prg_bank_bits > bsm_pkg::PRG_BITS_MAX) ?
                  bsm_pkg::PRG_BITS_MAX : cfg.prg_bank_bits;
        pcount  = 7'd1 << pbits;
        pmask   = 6'(pcount - 7'd1);
        psecond = (pbits == 3'd0) ? 6'd0 : 6'(pcount - 7'd2);
        case (req.address[14:13])
            2'd0:    praw = map_state.prg_swap_mode ? {2'b00, psecond} : map_state.banks[6];
            2'd1:    praw = map_state.banks[7];
            2'd2:    praw = map_state.prg_swap_mode ? map_state.banks[6] : {2'b00, psecond};
            default: praw = {2'b00, pmask};
        endcase
        pbank = praw[5:0] & pmask;

        cbits  = (cfg.chr_bank_bits > bsm_pkg::CHR_BITS_MAX) ?
                 bsm_pkg::CHR_BITS_MAX : cfg.chr_bank_bits;
        ccount = 9'd1 << cbits;
        cmask  = 8'(ccount - 9'd1);
        cslot  = req.address[12:10] ^ {map_state.chr_invert, 2'b00};
        // The lower half uses registers 0 and 1 as 2 KB pairs.
        if (!cslot[2])
            craw = {map_state.banks[{2'b00, cslot[1]}][7:1], cslot[0]};
        else
            craw = map_state.banks[cslot - 3'd2];
        chr_rom = {craw & cmask, req.address[9:0]};

        case (req.opcode)
            bsm_pkg::OP_PRG_READ: mapped_offset = {pbank, req.address[12:0]};
            bsm_pkg::OP_PPU_ADDR:
            begin
                if (cfg.chr_is_ram)
                    mapped_offset = {6'd0, req.address[12:0]};
                else
                    mapped_offset = {1'b0, chr_rom};
            end
            default: mapped_offset = 19'd0;
        endcase
    end

endmodule
`default_nettype wire

@@ src/bank_switch_mapper_scanline_irq_top.sv @@
// Top level: request register, configuration registers, result register.
// Pipeline: a request is captured in the request register, and its result,
// with done high, in the result register, from which the receiver takes it.
// Throughput: one request every cycle; busy stays low.
// The result is shown for one cycle only, since the receiver cannot stall.
// Reset is asynchronous: all bank, mirroring, RAM and counter state and the
// configuration registers return to their power-on values at once.
`default_nettype none
module bank_switch_mapper_scanline_irq_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bsm_pkg::request_t req,
    output logic                   done,
    output bsm_pkg::result_t       result,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [3:0]        cfg_data
);

    bsm_pkg::request_t   req_reg;
    logic                req_valid_reg;
    bsm_pkg::cfg_t       cfg_reg;
    bsm_pkg::map_state_t map_state;
    bsm_pkg::result_t    result_reg, result_next;
    logic                done_reg;
    logic                ram_ok;
    logic                mirror_next;
    logic                irq_pulse;
    logic [18:0]         mapped_offset;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else
            req_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            req_reg <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prg_bank_bits <= 3'd5;
            cfg_reg.chr_bank_bits <= 4'd8;
            cfg_reg.chr_is_ram    <= 1'b0;
            cfg_reg.quad_mirror   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bsm_pkg::CFG_PRG_BANK_BITS: cfg_reg.prg_bank_bits <= cfg_data[2:0];
                bsm_pkg::CFG_CHR_BANK_BITS: cfg_reg.chr_bank_bits <= cfg_data;
                bsm_pkg::CFG_CHR_IS_RAM:    cfg_reg.chr_is_ram    <= cfg_data[0];
                bsm_pkg::CFG_QUAD_MIRROR:   cfg_reg.quad_mirror   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    bsm_bank_regs u_bank_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (req_valid_reg),
        .req         (req_reg),
        .quad_mirror (cfg_reg.quad_mirror),
        .map_state   (map_state),
        .ram_ok      (ram_ok),
        .mirror_next (mirror_next)
    );

    bsm_irq u_irq (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (req_valid_reg),
        .req       (req_reg),
        .irq_pulse (irq_pulse)
    );

    bsm_map u_map (
        .req           (req_reg),
        .map_state     (map_state),
        .cfg           (cfg_reg),
        .mapped_offset (mapped_offset)
    );

    // Mirroring reports the state left behind by this request.
    always_comb
    begin
        result_next.mapped_offset = mapped_offset;
        result_next.ram_access_ok = ram_ok;
        result_next.irq_pulse     = irq_pulse;
        if (cfg_reg.quad_mirror)
            result_next.mirroring = bsm_pkg::MIRROR_FOUR;
        else if (mirror_next)
            result_next.mirroring = bsm_pkg::MIRROR_HORIZONTAL;
        else
            result_next.mirroring = bsm_pkg::MIRROR_VERTICAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
